// ===== src/ptts_pkg.sv =====
// ptts_pkg: shared types, constants and command/result codes for the
// periodic task tick scheduler. No dependencies.
package ptts_pkg;
  localparam int unsigned TableDepth = 32;
  localparam logic [28:0] CounterLimit = 29'd362880000;
  localparam logic [15:0] TickReset = 16'd100;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_REGISTER = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_PROCESS  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_CLEARED  = 3'd0,
    KIND_REGSTAT  = 3'd1,
    KIND_TICKDONE = 3'd2,
    KIND_DUE      = 3'd3,
    KIND_NONE     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] interval_ms;
  } job_t;
endpackage

// ===== src/ptts_if.sv =====
// ptts_if: valid/ready channel interfaces for input and result words.
// Depends on nothing.
interface ptts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] interval_ms;
  modport source (output valid, cmd, interval_ms, input ready);
  modport sink (input valid, cmd, interval_ms, output ready);
endinterface

interface ptts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [1:0] status;
  logic [4:0] task_index;
  logic       last;
  modport source (output valid, kind, status, task_index, last, input ready);
  modport sink (input valid, kind, status, task_index, last, output ready);
endinterface

// ===== src/ptts_queue.sv =====
// ptts_queue: short FIFO between front and back.
// Depends on ptts_pkg.
module ptts_queue #(
  parameter int unsigned Depth = ptts_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptts_pkg::job_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ptts_pkg::job_t  pop_data_o,
  output logic            empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  ptts_pkg::job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;

  assign full_o = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o)
        wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop_i && !empty_o)
        rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end
endmodule

// ===== src/ptts_divu.sv =====
// ptts_divu: radix-2 restoring remainder unit, one bit a cycle.
// Depends on nothing.
module ptts_divu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [28:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic        zero_rem_o
);
  logic [28:0] dvd_q;
  logic [16:0] rem_q;
  logic [15:0] dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] sh, sub;

  assign sh = {rem_q[15:0], dvd_q[28]};
  assign sub = sh - {1'b0, dvs_q};
  assign done_o = done_q;
  assign zero_rem_o = (rem_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd28) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[27:0], 1'b0};
      rem_q <= sub[16] ? sh : sub;
    end
  end
endmodule

// ===== src/ptts_back.sv =====
// ptts_back: executes queued commands against the entry table and emits
// result words. Depends on ptts_pkg, ptts_if, ptts_divu.
module ptts_back #(
  parameter int unsigned TableDepth = ptts_pkg::TableDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           job_valid_i,
  input  ptts_pkg::job_t job_i,
  output logic           job_pop_o,
  ptts_out_if.source     out_o
);
  localparam int unsigned IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_REG   = 7'b0000010,
    S_TRD   = 7'b0000100,
    S_TDIV  = 7'b0001000,
    S_PSCAN = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_RWAIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [15:0] tick_q;
  logic [28:0] ms_q;
  logic [CW-1:0] count_q;
  logic [TableDepth-1:0] pend_q;
  logic [15:0] ivl_mem [TableDepth];
  logic [15:0] rd_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] hidx_q;
  logic [IW-1:0] rd_addr;
  logic [15:0] jivl_q;
  logic dv_start, dv_done, dv_zero;
  logic ovalid_q;
  logic [2:0] kind_q;
  logic [1:0] stat_q;
  logic [4:0] tidx_q;
  logic last_q;
  logic found_q;
  logic [IW-1:0] nxt;
  logic nxt_ok;
  logic [29:0] ms_sum;
  logic [28:0] ms_next;
  logic obuf_free;

  assign obuf_free = !ovalid_q || out_o.ready;
  assign out_o.valid = ovalid_q;
  assign out_o.kind = kind_q;
  assign out_o.status = stat_q;
  assign out_o.task_index = tidx_q;
  assign out_o.last = last_q;

  assign ms_sum = {1'b0, ms_q} + {14'd0, tick_q};
  assign ms_next = (ms_sum > {1'b0, ptts_pkg::CounterLimit}) ? 29'(tick_q) : ms_sum[28:0];

  // tick walk: divides counter by entry interval; register: interval by tick
  assign dv_start = (state_q == S_TRD && nxt_ok) || (state_q == S_IDLE && job_valid_i &&
                    job_i.cmd == ptts_pkg::CMD_REGISTER && obuf_free);

  ptts_divu u_div (
    .clk_i, .rst_ni,
    .start_i   (dv_start),
    .dividend_i(state_q == S_TRD ? ms_q : {13'd0, job_i.interval_ms}),
    .divisor_i (state_q == S_TRD ? rd_q : tick_q),
    .done_o    (dv_done),
    .zero_rem_o(dv_zero)
  );

  assign nxt_ok = ({1'b0, idx_q} < (IW+1)'(count_q)) && ((IW+1)'(idx_q) < (IW+1)'(TableDepth));
  assign nxt = idx_q + 1'b1;

  // read address follows the index the walk uses next, so rd_q is ready in S_TRD
  assign rd_addr = (state_q == S_IDLE) ? '0 :
                   (state_q == S_TDIV && dv_done &&
                    (IW+1)'(idx_q) + 1 < (IW+1)'(TableDepth)) ? nxt : idx_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RWAIT && dv_done && dv_zero && jivl_q != '0 &&
        count_q < CW'(TableDepth))
      ivl_mem[count_q[IW-1:0]] <= jivl_q;
    rd_q <= ivl_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tick_q <= ptts_pkg::TickReset;
      ms_q <= '0;
      count_q <= '0;
      pend_q <= '0;
      ovalid_q <= 1'b0;
      idx_q <= '0;
      hidx_q <= '0;
      found_q <= 1'b0;
      jivl_q <= '0;
      kind_q <= '0; stat_q <= '0; tidx_q <= '0; last_q <= 1'b0;
    end else begin
      if (out_o.ready) ovalid_q <= 1'b0;
      if (cfg_we_i && cfg_wdata_i != '0 && !cfg_wdata_i[0]) begin
        tick_q <= cfg_wdata_i;
        count_q <= '0;
        pend_q <= '0;
      end
      case (state_q)
        S_IDLE: if (job_valid_i && obuf_free) begin
          case (job_i.cmd)
            ptts_pkg::CMD_CLEAR: begin
              count_q <= '0; pend_q <= '0;
              ovalid_q <= 1'b1; kind_q <= ptts_pkg::KIND_CLEARED;
              stat_q <= '0; tidx_q <= '0; last_q <= 1'b1;
            end
            ptts_pkg::CMD_REGISTER: begin
              jivl_q <= job_i.interval_ms;
              state_q <= S_RWAIT;
            end
            ptts_pkg::CMD_TICK: begin
              ms_q <= ms_next; idx_q <= '0;
              state_q <= S_TRD;
            end
            default: begin
              idx_q <= '0; found_q <= 1'b0;
              state_q <= S_PSCAN;
            end
          endcase
        end
        S_RWAIT: if (dv_done) begin
          ovalid_q <= 1'b1; kind_q <= ptts_pkg::KIND_REGSTAT; last_q <= 1'b1;
          tidx_q <= '0;
          if (count_q >= CW'(TableDepth)) stat_q <= ptts_pkg::ST_FULL;
          else if (jivl_q == '0 || !dv_zero) stat_q <= ptts_pkg::ST_BAD;
          else begin
            stat_q <= ptts_pkg::ST_OK;
            tidx_q <= 5'(count_q);
            pend_q[count_q[IW-1:0]] <= 1'b0;
            count_q <= count_q + 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_TRD: begin
          // rd_q holds the interval at idx_q; start its remainder or finish
          if (!nxt_ok) begin
            state_q <= S_REG;
          end else state_q <= S_TDIV;
        end
        S_TDIV: if (dv_done) begin
          if (rd_q != '0 && dv_zero) pend_q[idx_q] <= 1'b1;
          if ((IW+1)'(idx_q) + 1 >= (IW+1)'(TableDepth)) state_q <= S_REG;
          else begin idx_q <= nxt; state_q <= S_TRD; end
        end
        S_REG: if (obuf_free) begin
          ovalid_q <= 1'b1; kind_q <= ptts_pkg::KIND_TICKDONE;
          stat_q <= '0; tidx_q <= '0; last_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_PSCAN: begin
          if (!nxt_ok) begin
            state_q <= S_EMIT;
          end else if (!pend_q[idx_q] || !found_q || obuf_free) begin
            // each due word is held back until the next one is found so last can be set on the final one
            if (pend_q[idx_q]) begin
              if (found_q) begin
                ovalid_q <= 1'b1; kind_q <= ptts_pkg::KIND_DUE; stat_q <= '0;
                tidx_q <= 5'(hidx_q); last_q <= 1'b0;
              end
              found_q <= 1'b1;
              hidx_q <= idx_q;
              pend_q[idx_q] <= 1'b0;
            end
            if ((IW+1)'(idx_q) + 1 >= (IW+1)'(TableDepth)) state_q <= S_EMIT;
            else idx_q <= nxt;
          end
        end
        S_EMIT: if (obuf_free) begin
          ovalid_q <= 1'b1; stat_q <= '0; last_q <= 1'b1;
          if (found_q) begin
            kind_q <= ptts_pkg::KIND_DUE; tidx_q <= 5'(hidx_q);
          end else begin
            kind_q <= ptts_pkg::KIND_NONE; tidx_q <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign job_pop_o = (state_q == S_IDLE) && job_valid_i && obuf_free;
endmodule

// ===== src/ptts_front.sv =====
// ptts_front: accepts input words and pushes them into the job queue.
// Depends on ptts_pkg, ptts_if.
module ptts_front (
  ptts_in_if.sink        in_i,
  input  logic           full_i,
  output logic           push_o,
  output ptts_pkg::job_t job_o
);
  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && !full_i;
  assign job_o = '{cmd: in_i.cmd, interval_ms: in_i.interval_ms};
endmodule

// ===== src/periodic_task_tick_scheduler.sv =====
// periodic_task_tick_scheduler: top level of the periodic task scheduler.
// Depends on ptts_pkg, ptts_if, ptts_front, ptts_queue, ptts_back.
//
// Usage:
//  in_i  : command words (cmd, interval_ms), valid/ready.
//  out_o : result words (kind, status, task_index, last), valid/ready.
//  cfg_we_i/cfg_wdata_i : tick_ms; even nonzero writes take effect and
//  empty the table. Write only while idle.
// A front stage puts words into a two-deep queue; a back sequencer runs
// them one at a time, so input is taken while a result waits.
// Clear needs no remainder pass; register makes one pass of the bit-serial
// remainder unit (29 steps); tick makes one pass per table entry; process
// scans the entries one by one.
// Throughput: the next word starts when the back sequencer is idle again.
// Reset: counter, table count and pending flags cleared, tick_ms = 100.
// The interval store is not cleared; only entries below the count are read.
// A stalled receiver holds the result register and the back sequencer
// waits; the queue then fills and in_i.ready drops.
module periodic_task_tick_scheduler #(
  parameter int unsigned TableDepth = ptts_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ptts_in_if.sink     in_i,
  ptts_out_if.source  out_o
);
  logic push, full, pop, empty;
  ptts_pkg::job_t push_job, pop_job;

  ptts_front u_front (.in_i, .full_i(full), .push_o(push), .job_o(push_job));

  ptts_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_job), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_job), .empty_o(empty)
  );

  ptts_back #(.TableDepth(TableDepth)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .job_valid_i(!empty), .job_i(pop_job), .job_pop_o(pop), .out_o
  );
endmodule

// ===== src/ptts_checker.sv =====
// ptts_checker: port-level assertions for the scheduler, bound to the top.
// Depends on ptts_pkg.
module ptts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [1:0] out_status,
  input logic [4:0] out_task_index,
  input logic       out_last
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid &&
    $stable({out_kind, out_status, out_task_index, out_last})) else $error("hold");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_kind <= 3'd4) else $error("kind");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != ptts_pkg::KIND_DUE |-> out_last) else $error("last");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != ptts_pkg::KIND_REGSTAT |-> out_status == 2'd0)
    else $error("status");
endmodule

bind periodic_task_tick_scheduler ptts_checker u_chk (
  .clk_i, .rst_ni, .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_kind(out_o.kind), .out_status(out_o.status),
  .out_task_index(out_o.task_index), .out_last(out_o.last)
);

// ===== tb/periodic_task_tick_scheduler_test.sv =====
// periodic_task_tick_scheduler_test: self-checking bench for the periodic task
// tick scheduler. Uses ptts_pkg and the ptts_in_if / ptts_out_if channels.
// A scoreboard class predicts every result word; plain tasks drive the block.
module periodic_task_tick_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 1200;  // long enough for a worst-case tick pass
  localparam int unsigned IdleLimit = 40000;    // cycles with no word moving

  // Tracks table, counter and pending flags; holds the results still owed.
  class sched_scoreboard;
    typedef struct {
      ptts_pkg::kind_e   kind;
      ptts_pkg::status_e status;
      logic [4:0]        task_index;
      logic              last;
    } result_t;

    result_t     owed_q[$];
    int unsigned tick_ms;
    int unsigned ms_count;
    int unsigned n_entries;
    logic [15:0] interval_tab[ptts_pkg::TableDepth];
    bit          pending[ptts_pkg::TableDepth];
    int unsigned errors;

    function new();
      tick_ms = ptts_pkg::TickReset;
      ms_count = 0;
      errors = 0;
      empty_table();
    endfunction

    function void empty_table();
      n_entries = 0;
      foreach (pending[i]) pending[i] = 1'b0;
    endfunction

    // only even nonzero values take effect, and they wipe the table
    function void write_tick(logic [15:0] v);
      if (v != 0 && !v[0]) begin
        tick_ms = v;
        empty_table();
      end
    endfunction

    function void owe(ptts_pkg::kind_e k, ptts_pkg::status_e s, int unsigned idx, bit l);
      result_t r;
      r.kind = k;
      r.status = s;
      r.task_index = idx[4:0];
      r.last = l;
      owed_q.push_back(r);
    endfunction

    function void note(ptts_pkg::cmd_e c, logic [15:0] ivl);
      int n_due;
      n_due = 0;
      case (c)
        ptts_pkg::CMD_CLEAR: begin
          empty_table();
          owe(ptts_pkg::KIND_CLEARED, ptts_pkg::ST_OK, 0, 1'b1);
        end
        ptts_pkg::CMD_REGISTER: begin
          // full check wins over the interval check
          if (n_entries >= ptts_pkg::TableDepth) begin
            owe(ptts_pkg::KIND_REGSTAT, ptts_pkg::ST_FULL, 0, 1'b1);
          end else if (ivl == 0 || (ivl % tick_ms) != 0) begin
            owe(ptts_pkg::KIND_REGSTAT, ptts_pkg::ST_BAD, 0, 1'b1);
          end else begin
            interval_tab[n_entries] = ivl;
            pending[n_entries] = 1'b0;
            owe(ptts_pkg::KIND_REGSTAT, ptts_pkg::ST_OK, n_entries, 1'b1);
            n_entries++;
          end
        end
        ptts_pkg::CMD_TICK: begin
          ms_count += tick_ms;
          // wrap restarts at one tick
          if (ms_count > ptts_pkg::CounterLimit) ms_count = tick_ms;
          for (int i = 0; i < n_entries; i++) begin
            if (!pending[i] && (ms_count % interval_tab[i]) == 0) pending[i] = 1'b1;
          end
          owe(ptts_pkg::KIND_TICKDONE, ptts_pkg::ST_OK, 0, 1'b1);
        end
        default: begin
          for (int i = 0; i < n_entries; i++) begin
            if (pending[i]) begin
              owe(ptts_pkg::KIND_DUE, ptts_pkg::ST_OK, i, 1'b0);
              pending[i] = 1'b0;
              n_due++;
            end
          end
          if (n_due == 0) owe(ptts_pkg::KIND_NONE, ptts_pkg::ST_OK, 0, 1'b1);
          else owed_q[$].last = 1'b1;
        end
      endcase
    endfunction

    function void check(logic [2:0] k, logic [1:0] s, logic [4:0] idx, logic l);
      result_t e;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: kind %0d status %0d index %0d last %0d",
                   k, s, idx, l);
        return;
      end
      e = owed_q.pop_front();
      if (k !== e.kind || s !== e.status || idx !== e.task_index || l !== e.last) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: expected kind %0d status %0d index %0d last %0d,",
                    " got kind %0d status %0d index %0d last %0d"},
                   e.kind, e.status, e.task_index, e.last, k, s, idx, l);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  ptts_in_if   in_ch ();
  ptts_out_if  out_ch ();

  sched_scoreboard sched_sb;
  int unsigned     idle_cycles;

  periodic_task_tick_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Monitor: every handshake is seen at the rising edge. Input words feed the
  // prediction, result words are checked, and a watchdog counts dead cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        sched_sb.note(ptts_pkg::cmd_e'(in_ch.cmd), in_ch.interval_ms);
      if (out_ch.valid && out_ch.ready)
        sched_sb.check(out_ch.kind, out_ch.status, out_ch.task_index, out_ch.last);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: per result word, hold ready low for a random delay drawn with $urandom_range, then take it.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Sender: optional gap, then hold the word until accepted. valid stays high
  // across back-to-back words. Leaves time at the falling edge after acceptance.
  task automatic send(ptts_pkg::cmd_e c, logic [15:0] ivl, bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = c;
    in_ch.interval_ms = ivl;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Sender pause: wait until every owed result has come back.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sched_sb.owed_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_tick(logic [15:0] v);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sched_sb.write_tick(v);
  endtask

  // mostly valid multiples of the tick, small ones favored; some raw values
  function automatic logic [15:0] pick_interval();
    int unsigned kmax;
    kmax = 65535 / sched_sb.tick_ms;
    if ($urandom_range(0, 4) == 0) return 16'($urandom());
    if ($urandom_range(0, 1) == 0) return 16'(sched_sb.tick_ms * $urandom_range(1, 6));
    return 16'(sched_sb.tick_ms * $urandom_range(1, kmax));
  endfunction

  // Random traffic: register between 2 and 10 entries, then a mix biased toward ticks and process.
  task automatic run_phase(int unsigned n_items);
    int unsigned r;
    bit          gaps;
    gaps = $urandom_range(0, 3) != 0;  // some phases run with no gaps at all
    repeat ($urandom_range(2, 10)) send(ptts_pkg::CMD_REGISTER, pick_interval(), gaps);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send(ptts_pkg::CMD_CLEAR, 16'($urandom()), gaps);
      else if (r < 30) send(ptts_pkg::CMD_REGISTER, pick_interval(), gaps);
      else if (r < 65) send(ptts_pkg::CMD_TICK, 16'($urandom()), gaps);
      else send(ptts_pkg::CMD_PROCESS, 16'($urandom()), gaps);
      if ($urandom_range(0, 40) == 0) drain();
    end
  endtask

  initial begin
    sched_sb = new();
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = ptts_pkg::CMD_CLEAR;
    in_ch.interval_ms = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset tick of 100
    send(ptts_pkg::CMD_PROCESS, 16'hffff);    // nothing due
    send(ptts_pkg::CMD_REGISTER, 16'd0);      // zero interval
    send(ptts_pkg::CMD_REGISTER, 16'd150);    // not a tick multiple
    send(ptts_pkg::CMD_REGISTER, 16'hffff);
    send(ptts_pkg::CMD_REGISTER, 16'd100);
    send(ptts_pkg::CMD_REGISTER, 16'd200);
    send(ptts_pkg::CMD_REGISTER, 16'd65500);
    send(ptts_pkg::CMD_TICK, 16'd0);
    send(ptts_pkg::CMD_TICK, 16'hffff);       // 200: two entries due
    send(ptts_pkg::CMD_TICK, 16'd0);          // already pending stays pending
    send(ptts_pkg::CMD_PROCESS, 16'd0);
    send(ptts_pkg::CMD_PROCESS, 16'd0);
    send(ptts_pkg::CMD_TICK, 16'd0);
    send(ptts_pkg::CMD_CLEAR, 16'd0);         // clear also drops pending flags
    send(ptts_pkg::CMD_PROCESS, 16'd0);
    drain();
    // fill the table past its depth
    for (int i = 0; i <= ptts_pkg::TableDepth; i++)
      send(ptts_pkg::CMD_REGISTER, 16'(100 * (i + 1)), 1'b0);
    send(ptts_pkg::CMD_TICK, 16'd0);
    send(ptts_pkg::CMD_PROCESS, 16'd0);

    // ignored writes keep tick and table; then the extremes and a few in between
    set_tick(16'd0);
    set_tick(16'hffff);
    send(ptts_pkg::CMD_REGISTER, 16'd0);      // still full
    run_phase(40);
    set_tick(16'd2);
    run_phase(40);
    set_tick(16'd10);
    run_phase(40);
    set_tick(16'd65534);
    run_phase(30);
    set_tick(16'd50);
    run_phase(30);
    set_tick(16'd100);
    run_phase(20);

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (sched_sb.errors == 0 && sched_sb.owed_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
